// ----- rtl/pis_pkg.sv -----
// pursuit intercept solver: shared types, constants and the angle table
// no dependencies
package pis_pkg;

  localparam int unsigned ITERATIONS   = 32;
  localparam int unsigned CORDIC_STEPS = 20;

  localparam logic signed [26:0] DEG90  = 27'sd5898240;
  localparam logic signed [26:0] DEG180 = 27'sd11796480;
  localparam logic signed [26:0] DEG360 = 27'sd23592960;
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

  localparam logic signed [17:0] UNIT_POS = 18'sd65536;
  localparam logic signed [17:0] UNIT_NEG = -18'sd65536;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic [30:0]        u;
    logic [30:0]        v;
    logic [30:0]        lo;
    logic [30:0]        hi;
    logic signed [17:0] c;
    logic signed [17:0] s;
    logic               found;
    logic [30:0]        bt;
    logic signed [47:0] bx;
    logic signed [47:0] by;
  } ctx_t;

  // atan(2^-i) in q16.16 degrees
  function automatic logic [21:0] atan_deg(input int unsigned idx);
    logic [21:0] r;
    unique case (idx)
      0:  r = 22'd2949120;
      1:  r = 22'd1740967;
      2:  r = 22'd919879;
      3:  r = 22'd466945;
      4:  r = 22'd234379;
      5:  r = 22'd117304;
      6:  r = 22'd58666;
      7:  r = 22'd29335;
      8:  r = 22'd14668;
      9:  r = 22'd7334;
      10: r = 22'd3667;
      11: r = 22'd1833;
      12: r = 22'd917;
      13: r = 22'd458;
      14: r = 22'd229;
      15: r = 22'd115;
      16: r = 22'd57;
      17: r = 22'd29;
      18: r = 22'd14;
      19: r = 22'd7;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/pursuit_intercept_solver.sv -----
// throughput: one word per cycle while the output word is not held; every stage is a
// register, one bisection step is six stages (midpoint multiply, heading multiply,
// point, square partials, squares, compare)
// one pipeline-wide enable stalls all stages while the output word waits
// reset: asynchronous, active low, clears the valid bits of all stages
// top level: heading cordic, bisection chain of pis_iter, bearing cordic; uses pis_pkg
module pursuit_intercept_solver (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] pursuer_x_i,
  input  logic signed [31:0] pursuer_y_i,
  input  logic signed [31:0] target_x_i,
  input  logic signed [31:0] target_y_i,
  input  logic [24:0]        heading_deg_i,
  input  logic [30:0]        target_speed_i,
  input  logic [30:0]        pursuer_speed_i,
  input  logic [30:0]        time_limit_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               found_o,
  output logic [24:0]        bearing_deg_o,
  output logic [30:0]        intercept_time_o,
  output logic signed [31:0] intercept_x_o,
  output logic signed [31:0] intercept_y_o
);

  localparam int unsigned NSTEP = pis_pkg::CORDIC_STEPS;
  localparam int unsigned NITER = pis_pkg::ITERATIONS;

  typedef struct packed {
    pis_pkg::ctx_t      ctx;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [26:0] a;
  } hd_t;

  typedef struct packed {
    logic               found;
    logic [30:0]        bt;
    logic signed [31:0] ix;
    logic signed [31:0] iy;
    logic               xneg;
    logic               yneg;
    logic               zero;
    logic signed [51:0] x;
    logic signed [51:0] y;
    logic signed [25:0] z;
  } br_t;

  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // heading reduction
  hd_t hd0_d;

  always_comb begin
    logic signed [26:0] a;
    a = $signed({2'b00, heading_deg_i});
    if (a >= pis_pkg::DEG360) begin
      a = a - pis_pkg::DEG360;
    end
    if (a > pis_pkg::DEG180) begin
      a = a - pis_pkg::DEG360;
    end
    hd0_d          = '0;
    hd0_d.ctx.px   = pursuer_x_i;
    hd0_d.ctx.py   = pursuer_y_i;
    hd0_d.ctx.tx   = target_x_i;
    hd0_d.ctx.ty   = target_y_i;
    hd0_d.ctx.u    = target_speed_i;
    hd0_d.ctx.v    = pursuer_speed_i;
    hd0_d.ctx.lo   = '0;
    hd0_d.ctx.hi   = time_limit_i;
    priority if (a > pis_pkg::DEG90) begin
      hd0_d.x = '0;
      hd0_d.y = pis_pkg::GAIN_Q30;
      hd0_d.a = a - pis_pkg::DEG90;
    end else if (a < -pis_pkg::DEG90) begin
      hd0_d.x = '0;
      hd0_d.y = -pis_pkg::GAIN_Q30;
      hd0_d.a = a + pis_pkg::DEG90;
    end else begin
      hd0_d.x = pis_pkg::GAIN_Q30;
      hd0_d.y = '0;
      hd0_d.a = a;
    end
  end

  hd_t  hd_q   [NSTEP+1];
  logic hd_vld_q [NSTEP+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hd_vld_q[0] <= 1'b0;
    end else if (en) begin
      hd_vld_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hd_q[0] <= hd0_d;
    end
  end

  // rotation cordic, one step a stage
  for (genvar i = 0; i < NSTEP; i++) begin : g_hd
    hd_t step_d;
    logic signed [26:0] at;

    assign at = $signed({5'b00000, pis_pkg::atan_deg(i)});

    always_comb begin
      step_d = hd_q[i];
      if (!hd_q[i].a[26]) begin
        step_d.x = hd_q[i].x - (hd_q[i].y >>> i);
        step_d.y = hd_q[i].y + (hd_q[i].x >>> i);
        step_d.a = hd_q[i].a - at;
      end else begin
        step_d.x = hd_q[i].x + (hd_q[i].y >>> i);
        step_d.y = hd_q[i].y - (hd_q[i].x >>> i);
        step_d.a = hd_q[i].a + at;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        hd_vld_q[i+1] <= 1'b0;
      end else if (en) begin
        hd_vld_q[i+1] <= hd_vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        hd_q[i+1] <= step_d;
      end
    end
  end

  // round to q.16 and clamp to the unit range
  logic signed [33:0] xr, yr;
  logic signed [17:0] c_d, s_d;

  assign xr = (hd_q[NSTEP].x + 34'sd8192) >>> 14;
  assign yr = (hd_q[NSTEP].y + 34'sd8192) >>> 14;

  always_comb begin
    priority if (xr > 34'(pis_pkg::UNIT_POS)) begin
      c_d = pis_pkg::UNIT_POS;
    end else if (xr < 34'(pis_pkg::UNIT_NEG)) begin
      c_d = pis_pkg::UNIT_NEG;
    end else begin
      c_d = xr[17:0];
    end
    priority if (yr > 34'(pis_pkg::UNIT_POS)) begin
      s_d = pis_pkg::UNIT_POS;
    end else if (yr < 34'(pis_pkg::UNIT_NEG)) begin
      s_d = pis_pkg::UNIT_NEG;
    end else begin
      s_d = yr[17:0];
    end
  end

  pis_pkg::ctx_t it_ctx [NITER+1];
  logic          it_vld [NITER+1];
  pis_pkg::ctx_t it0_d;

  always_comb begin
    it0_d   = hd_q[NSTEP].ctx;
    it0_d.c = c_d;
    it0_d.s = s_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      it_vld[0] <= 1'b0;
    end else if (en) begin
      it_vld[0] <= hd_vld_q[NSTEP];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      it_ctx[0] <= it0_d;
    end
  end

  // bisection chain
  for (genvar j = 0; j < NITER; j++) begin : g_it
    pis_iter u_iter (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (it_vld[j]),
      .ctx_i   (it_ctx[j]),
      .valid_o (it_vld[j+1]),
      .ctx_o   (it_ctx[j+1])
    );
  end

  // bearing: offsets, magnitudes and saturated point
  pis_pkg::ctx_t      fc;
  logic signed [47:0] bdx, bdy, nbdx, nbdy;
  br_t                br0_d;

  assign fc   = it_ctx[NITER];
  assign bdx  = fc.bx - {{16{fc.px[31]}}, fc.px};
  assign bdy  = fc.by - {{16{fc.py[31]}}, fc.py};
  assign nbdx = -bdx;
  assign nbdy = -bdy;

  always_comb begin
    br0_d       = '0;
    br0_d.found = fc.found;
    br0_d.bt    = fc.bt;
    br0_d.xneg  = bdx[47];
    br0_d.yneg  = bdy[47];
    br0_d.zero  = (bdx == '0) && (bdy == '0);
    br0_d.x     = $signed({5'b00000, bdx[47] ? nbdx[46:0] : bdx[46:0]});
    br0_d.y     = $signed({5'b00000, bdy[47] ? nbdy[46:0] : bdy[46:0]});
    priority if (fc.bx > 48'sh0000_7FFF_FFFF) begin
      br0_d.ix = 32'sh7FFF_FFFF;
    end else if (fc.bx < -48'sh0000_8000_0000) begin
      br0_d.ix = 32'sh8000_0000;
    end else begin
      br0_d.ix = fc.bx[31:0];
    end
    priority if (fc.by > 48'sh0000_7FFF_FFFF) begin
      br0_d.iy = 32'sh7FFF_FFFF;
    end else if (fc.by < -48'sh0000_8000_0000) begin
      br0_d.iy = 32'sh8000_0000;
    end else begin
      br0_d.iy = fc.by[31:0];
    end
  end

  localparam int unsigned NNORM = 3;
  localparam int unsigned NBR   = 1 + NNORM + NSTEP;

  br_t  br_q   [NBR];
  logic br_vld_q [NBR];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      br_vld_q[0] <= 1'b0;
    end else if (en) begin
      br_vld_q[0] <= it_vld[NITER];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      br_q[0] <= br0_d;
    end
  end

  // normalise until one magnitude reaches 2^40, two shift steps a stage
  for (genvar n = 0; n < NNORM; n++) begin : g_norm
    localparam int unsigned KA = 64 >> (2 * n + 1);
    localparam int unsigned KB = 64 >> (2 * n + 2);
    br_t norm_d;

    always_comb begin
      norm_d = br_q[n];
      if ((norm_d.x | norm_d.y) < (52'sd1 <<< (41 - KA))) begin
        norm_d.x = norm_d.x <<< KA;
        norm_d.y = norm_d.y <<< KA;
      end
      if ((norm_d.x | norm_d.y) < (52'sd1 <<< (41 - KB))) begin
        norm_d.x = norm_d.x <<< KB;
        norm_d.y = norm_d.y <<< KB;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        br_vld_q[n+1] <= 1'b0;
      end else if (en) begin
        br_vld_q[n+1] <= br_vld_q[n];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        br_q[n+1] <= norm_d;
      end
    end
  end

  // vectoring cordic, one step a stage
  for (genvar i = 0; i < NSTEP; i++) begin : g_vec
    localparam int unsigned P = 1 + NNORM + i;
    br_t vec_d;
    logic signed [25:0] at;

    assign at = $signed({4'b0000, pis_pkg::atan_deg(i)});

    always_comb begin
      vec_d = br_q[P-1];
      if (br_q[P-1].y > 52'sd0) begin
        vec_d.x = br_q[P-1].x + (br_q[P-1].y >>> i);
        vec_d.y = br_q[P-1].y - (br_q[P-1].x >>> i);
        vec_d.z = br_q[P-1].z + at;
      end else begin
        vec_d.x = br_q[P-1].x - (br_q[P-1].y >>> i);
        vec_d.y = br_q[P-1].y + (br_q[P-1].x >>> i);
        vec_d.z = br_q[P-1].z - at;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        br_vld_q[P] <= 1'b0;
      end else if (en) begin
        br_vld_q[P] <= br_vld_q[P-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        br_q[P] <= vec_d;
      end
    end
  end

  // quadrant placement and output word
  br_t         bl;
  logic [24:0] zc, rb, bear_d;
  logic [24:0] d90, d180, d360;

  assign bl   = br_q[NBR-1];
  assign d90  = pis_pkg::DEG90[24:0];
  assign d180 = pis_pkg::DEG180[24:0];
  assign d360 = pis_pkg::DEG360[24:0];

  always_comb begin
    priority if (bl.z[25]) begin
      zc = '0;
    end else if (bl.z > 26'(pis_pkg::DEG90)) begin
      zc = d90;
    end else begin
      zc = bl.z[24:0];
    end
    priority if (!bl.xneg && !bl.yneg) begin
      rb = zc;
    end else if (bl.xneg && !bl.yneg) begin
      rb = d180 - zc;
    end else if (bl.xneg) begin
      rb = d180 + zc;
    end else begin
      rb = d360 - zc;
    end
    if (rb >= d360) begin
      rb = rb - d360;
    end
    bear_d = bl.zero ? '0 : rb;
  end

  logic               out_vld_q;
  logic               found_q;
  logic [24:0]        bear_q;
  logic [30:0]        time_q;
  logic signed [31:0] ix_q, iy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= br_vld_q[NBR-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      found_q <= bl.found;
      bear_q  <= bl.found ? bear_d : '0;
      time_q  <= bl.found ? bl.bt : '0;
      ix_q    <= bl.found ? bl.ix : '0;
      iy_q    <= bl.found ? bl.iy : '0;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign found_o          = found_q;
  assign bearing_deg_o    = bear_q;
  assign intercept_time_o = time_q;
  assign intercept_x_o    = ix_q;
  assign intercept_y_o    = iy_q;

endmodule

// ----- rtl/pis_iter.sv -----
// one bisection step over time as a six stage pipeline
// depends on pis_pkg
module pis_iter (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  pis_pkg::ctx_t ctx_i,
  output logic          valid_o,
  output pis_pkg::ctx_t ctx_o
);

  logic [5:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  assign valid_o = vld_q[5];

  // stage 1: midpoint, travel and reach
  logic [31:0] sum_lh;
  logic [30:0] mid_d;
  logic [61:0] trav_full, reach_full;

  assign sum_lh     = {1'b0, ctx_i.lo} + {1'b0, ctx_i.hi};
  assign mid_d      = sum_lh[31:1];
  assign trav_full  = 62'(ctx_i.u) * 62'(mid_d);
  assign reach_full = 62'(ctx_i.v) * 62'(mid_d);

  pis_pkg::ctx_t s1_ctx_q;
  logic [30:0]   s1_mid_q;
  logic [45:0]   s1_trav_q, s1_reach_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_ctx_q   <= ctx_i;
      s1_mid_q   <= mid_d;
      s1_trav_q  <= trav_full[61:16];
      s1_reach_q <= reach_full[61:16];
    end
  end

  // stage 2: offset along the heading
  logic signed [64:0] offx_full, offy_full;

  assign offx_full = $signed({1'b0, s1_trav_q}) * s1_ctx_q.c;
  assign offy_full = $signed({1'b0, s1_trav_q}) * s1_ctx_q.s;

  pis_pkg::ctx_t      s2_ctx_q;
  logic [30:0]        s2_mid_q;
  logic [45:0]        s2_reach_q;
  logic signed [47:0] s2_offx_q, s2_offy_q;
  logic signed [32:0] s2_dtx_q, s2_dty_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_ctx_q   <= s1_ctx_q;
      s2_mid_q   <= s1_mid_q;
      s2_reach_q <= s1_reach_q;
      s2_offx_q  <= offx_full[63:16];
      s2_offy_q  <= offy_full[63:16];
      s2_dtx_q   <= {s1_ctx_q.tx[31], s1_ctx_q.tx} - {s1_ctx_q.px[31], s1_ctx_q.px};
      s2_dty_q   <= {s1_ctx_q.ty[31], s1_ctx_q.ty} - {s1_ctx_q.py[31], s1_ctx_q.py};
    end
  end

  // stage 3: target point and distance magnitudes
  logic signed [47:0] nx_d, ny_d, dx_d, dy_d, ndx_d, ndy_d;
  logic [46:0]        ax_d, ay_d;

  assign nx_d  = s2_offx_q + {{16{s2_ctx_q.tx[31]}}, s2_ctx_q.tx};
  assign ny_d  = s2_offy_q + {{16{s2_ctx_q.ty[31]}}, s2_ctx_q.ty};
  assign dx_d  = s2_offx_q + {{15{s2_dtx_q[32]}}, s2_dtx_q};
  assign dy_d  = s2_offy_q + {{15{s2_dty_q[32]}}, s2_dty_q};
  assign ndx_d = -dx_d;
  assign ndy_d = -dy_d;
  assign ax_d  = dx_d[47] ? ndx_d[46:0] : dx_d[46:0];
  assign ay_d  = dy_d[47] ? ndy_d[46:0] : dy_d[46:0];

  pis_pkg::ctx_t      s3_ctx_q;
  logic [30:0]        s3_mid_q;
  logic signed [47:0] s3_nx_q, s3_ny_q;
  logic [46:0]        s3_op_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_ctx_q   <= s2_ctx_q;
      s3_mid_q   <= s2_mid_q;
      s3_nx_q    <= nx_d;
      s3_ny_q    <= ny_d;
      s3_op_q[0] <= {1'b0, s2_reach_q};
      s3_op_q[1] <= ax_d;
      s3_op_q[2] <= ay_d;
    end
  end

  // stage 4: partial products of the three squares
  logic [47:0] p0_d [3];
  logic [46:0] p1_d [3];
  logic [45:0] p2_d [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p0_d[k] = 48'(s3_op_q[k][23:0]) * 48'(s3_op_q[k][23:0]);
      p1_d[k] = 47'(s3_op_q[k][23:0]) * 47'(s3_op_q[k][46:24]);
      p2_d[k] = 46'(s3_op_q[k][46:24]) * 46'(s3_op_q[k][46:24]);
    end
  end

  pis_pkg::ctx_t      s4_ctx_q;
  logic [30:0]        s4_mid_q;
  logic signed [47:0] s4_nx_q, s4_ny_q;
  logic [47:0]        s4_p0_q [3];
  logic [46:0]        s4_p1_q [3];
  logic [45:0]        s4_p2_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_ctx_q <= s3_ctx_q;
      s4_mid_q <= s3_mid_q;
      s4_nx_q  <= s3_nx_q;
      s4_ny_q  <= s3_ny_q;
      s4_p0_q  <= p0_d;
      s4_p1_q  <= p1_d;
      s4_p2_q  <= p2_d;
    end
  end

  // stage 5: assemble squares
  logic [93:0] sq_d [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sq_d[k] = (94'(s4_p2_q[k]) << 48) + (94'(s4_p1_q[k]) << 25) + 94'(s4_p0_q[k]);
    end
  end

  pis_pkg::ctx_t      s5_ctx_q;
  logic [30:0]        s5_mid_q;
  logic signed [47:0] s5_nx_q, s5_ny_q;
  logic [93:0]        s5_sq_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s5_ctx_q <= s4_ctx_q;
      s5_mid_q <= s4_mid_q;
      s5_nx_q  <= s4_nx_q;
      s5_ny_q  <= s4_ny_q;
      s5_sq_q  <= sq_d;
    end
  end

  // stage 6: compare and narrow the interval
  logic [94:0]   dist_sq;
  logic          hit;
  pis_pkg::ctx_t ctx_d;

  assign dist_sq = 95'(s5_sq_q[1]) + 95'(s5_sq_q[2]);
  assign hit     = 95'(s5_sq_q[0]) > dist_sq;

  always_comb begin
    ctx_d = s5_ctx_q;
    if (hit) begin
      ctx_d.found = 1'b1;
      ctx_d.bt    = s5_mid_q;
      ctx_d.bx    = s5_nx_q;
      ctx_d.by    = s5_ny_q;
      ctx_d.hi    = s5_mid_q;
    end else begin
      ctx_d.lo    = s5_mid_q;
    end
  end

  pis_pkg::ctx_t s6_ctx_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s6_ctx_q <= ctx_d;
    end
  end

  assign ctx_o = s6_ctx_q;

endmodule

// ----- tb/pursuit_intercept_solver_tb.sv -----
// testbench for pursuit_intercept_solver: directed and random intercept queries with
// random idling on both handshakes, checked against a local bit-exact predictor
// depends on rtl/pis_pkg.sv, rtl/pursuit_intercept_solver.sv and rtl/pis_iter.sv
`timescale 1ns / 1ps

module pursuit_intercept_solver_tb;

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic [24:0]        heading;
    logic [30:0]        tspeed;
    logic [30:0]        pspeed;
    logic [30:0]        tlimit;
  } query_t;

  typedef struct {
    logic               found;
    logic [24:0]        bearing;
    logic [30:0]        itime;
    logic signed [31:0] ix;
    logic signed [31:0] iy;
  } intercept_t;

  localparam longint ANG90  = 64'sd5898240;
  localparam longint ANG180 = 64'sd11796480;
  localparam longint ANG360 = 64'sd23592960;
  localparam longint ATAN_TAB [0:19] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
  };

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic signed [31:0] pursuer_x_i;
  logic signed [31:0] pursuer_y_i;
  logic signed [31:0] target_x_i;
  logic signed [31:0] target_y_i;
  logic [24:0]        heading_deg_i;
  logic [30:0]        target_speed_i;
  logic [30:0]        pursuer_speed_i;
  logic [30:0]        time_limit_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               found_o;
  logic [24:0]        bearing_deg_o;
  logic [30:0]        intercept_time_o;
  logic signed [31:0] intercept_x_o;
  logic signed [31:0] intercept_y_o;

  intercept_t pending_intercepts[$];
  int         mismatches;
  int         words_sent;
  int         words_checked;
  int         found_count;
  bit         no_idle;

  pursuit_intercept_solver u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .pursuer_x_i      (pursuer_x_i),
    .pursuer_y_i      (pursuer_y_i),
    .target_x_i       (target_x_i),
    .target_y_i       (target_y_i),
    .heading_deg_i    (heading_deg_i),
    .target_speed_i   (target_speed_i),
    .pursuer_speed_i  (pursuer_speed_i),
    .time_limit_i     (time_limit_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .found_o          (found_o),
    .bearing_deg_o    (bearing_deg_o),
    .intercept_time_o (intercept_time_o),
    .intercept_x_o    (intercept_x_o),
    .intercept_y_o    (intercept_y_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void heading_unit(input logic [24:0] h, output longint c,
                                       output longint s);
    longint a, x, y, sx, sy;
    a = longint'(h);
    x = longint'(pis_pkg::GAIN_Q30);
    y = 0;
    if (a >= ANG360) a -= ANG360;
    if (a > ANG180) a -= ANG360;
    if (a > ANG90) begin
      x = 0; y = longint'(pis_pkg::GAIN_Q30); a -= ANG90;
    end else if (a < -ANG90) begin
      x = 0; y = -longint'(pis_pkg::GAIN_Q30); a += ANG90;
    end
    for (int i = 0; i < 20; i++) begin
      sx = y >>> i;
      sy = x >>> i;
      if (a >= 0) begin
        x -= sx; y += sy; a -= ATAN_TAB[i];
      end else begin
        x += sx; y -= sy; a += ATAN_TAB[i];
      end
    end
    c = (x + 8192) >>> 14;
    s = (y + 8192) >>> 14;
    if (c > 65536) c = 65536;
    if (c < -65536) c = -65536;
    if (s > 65536) s = 65536;
    if (s < -65536) s = -65536;
  endfunction

  function automatic longint bearing_to(input longint dx, input longint dy);
    longint ax, ay, x, y, z, sx, sy, r;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    z = 0;
    if ((ax | ay) == 0) return 0;
    while ((ax | ay) < (64'sd1 <<< 40)) begin
      ax = ax <<< 1; ay = ay <<< 1;
    end
    x = ax; y = ay;
    for (int i = 0; i < 20; i++) begin
      sx = y >>> i;
      sy = x >>> i;
      if (y > 0) begin
        x += sx; y -= sy; z += ATAN_TAB[i];
      end else begin
        x -= sx; y += sy; z -= ATAN_TAB[i];
      end
    end
    if (z < 0) z = 0;
    if (z > ANG90) z = ANG90;
    if (dx >= 0 && dy >= 0) r = z;
    else if (dx < 0 && dy >= 0) r = ANG180 - z;
    else if (dx < 0) r = ANG180 + z;
    else r = ANG360 - z;
    if (r >= ANG360) r -= ANG360;
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic intercept_t predict_intercept(input query_t q);
    intercept_t   res;
    longint       c, s, lo, hi, mid, travel, reach, nx, ny, dx, dy, bx, by, bt;
    logic [127:0] reach_sq, dist_sq, wa, wb, wr;
    bit           hit;
    heading_unit(q.heading, c, s);
    lo = 0; hi = longint'(q.tlimit);
    hit = 0; bt = 0; bx = 0; by = 0;
    for (int it = 0; it < pis_pkg::ITERATIONS; it++) begin
      mid = (lo + hi) >> 1;
      travel = (longint'(q.tspeed) * mid) >> 16;
      reach = (longint'(q.pspeed) * mid) >> 16;
      nx = longint'(q.tx) + ((travel * c) >>> 16);
      ny = longint'(q.ty) + ((travel * s) >>> 16);
      dx = nx - longint'(q.px);
      dy = ny - longint'(q.py);
      wr = 128'(reach);
      wa = 128'((dx < 0) ? -dx : dx);
      wb = 128'((dy < 0) ? -dy : dy);
      reach_sq = wr * wr;
      dist_sq = wa * wa + wb * wb;
      if (reach_sq > dist_sq) begin
        hit = 1; bt = mid; bx = nx; by = ny; hi = mid;
      end else begin
        lo = mid;
      end
    end
    res = '{found: 1'b0, bearing: '0, itime: '0, ix: '0, iy: '0};
    if (hit) begin
      res.found = 1'b1;
      res.bearing = 25'(bearing_to(bx - longint'(q.px), by - longint'(q.py)));
      res.itime = bt[30:0];
      res.ix = sat32(bx);
      res.iy = sat32(by);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on %s at word %0d: got %0d, expected %0d",
             what, words_checked, got, want);
    mismatches++;
  endtask

  task automatic send_query(input query_t q);
    int gap;
    bit rdy;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    pursuer_x_i     <= q.px;
    pursuer_y_i     <= q.py;
    target_x_i      <= q.tx;
    target_y_i      <= q.ty;
    heading_deg_i   <= q.heading;
    target_speed_i  <= q.tspeed;
    pursuer_speed_i <= q.pspeed;
    time_limit_i    <= q.tlimit;
    do begin
      @(negedge clk_i);
      rdy = in_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    pending_intercepts.insert(pending_intercepts.size(), predict_intercept(q));
    words_sent++;
  endtask

  task automatic release_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin : result_checker
    intercept_t want;
    int  stall;
    bit  v;
    logic f;
    logic [24:0] b;
    logic [30:0] t;
    logic signed [31:0] x, y;
    wait (rst_ni === 1'b1);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do begin
        @(negedge clk_i);
        v = out_valid_o;
        f = found_o; b = bearing_deg_o; t = intercept_time_o;
        x = intercept_x_o; y = intercept_y_o;
        @(posedge clk_i);
      end while (!v);
      if (pending_intercepts.size() == 0) begin
        $display("unexpected result word");
        mismatches++;
      end else begin
        want = pending_intercepts.pop_front();
        if (f !== want.found) report_mismatch("found", f, want.found);
        if (b !== want.bearing) report_mismatch("bearing", b, want.bearing);
        if (t !== want.itime) report_mismatch("time", t, want.itime);
        if (x !== want.ix) report_mismatch("x", x, want.ix);
        if (y !== want.iy) report_mismatch("y", y, want.iy);
        if (want.found) found_count++;
      end
      words_checked++;
    end
  end

  function automatic query_t make_query(input bit tidy);
    query_t q;
    if (tidy) begin
      q.px = $signed($urandom_range(0, 32'd131072000)) - 32'sd65536000;
      q.py = $signed($urandom_range(0, 32'd131072000)) - 32'sd65536000;
      q.tx = $signed($urandom_range(0, 32'd131072000)) - 32'sd65536000;
      q.ty = $signed($urandom_range(0, 32'd131072000)) - 32'sd65536000;
      q.heading = 25'($urandom_range(0, 23592959));
      q.tspeed = 31'($urandom_range(0, 50 << 16));
      q.pspeed = 31'($urandom_range(0, 100 << 16));
      q.tlimit = 31'($urandom_range(0, 200 << 16));
    end else begin
      q.px = $urandom; q.py = $urandom; q.tx = $urandom; q.ty = $urandom;
      q.heading = 25'($urandom);
      q.tspeed = 31'($urandom); q.pspeed = 31'($urandom); q.tlimit = 31'($urandom);
    end
    return q;
  endfunction

  function automatic query_t mk(input int px, py, tx, ty, input int unsigned h, u, v, l);
    query_t q;
    q.px = px; q.py = py; q.tx = tx; q.ty = ty;
    q.heading = 25'(h); q.tspeed = 31'(u); q.pspeed = 31'(v); q.tlimit = 31'(l);
    return q;
  endfunction

  task automatic test_directed_edges();
    // zero limit, zero distance, stationary target, unreachable target
    send_query(mk(0, 0, 0, 0, 0, 0, 0, 0));
    send_query(mk(0, 0, 0, 0, 0, 0, 65536, 10 << 16));
    send_query(mk(5 << 16, -3 << 16, 5 << 16, -3 << 16, 90 << 16, 0, 1 << 16, 1 << 16));
    send_query(mk(0, 0, 10 << 16, 0, 0, 0, 2 << 16, 100 << 16));
    send_query(mk(0, 0, 10 << 16, 10 << 16, 45 << 16, 5 << 16, 1 << 16, 100 << 16));
    send_query(mk(0, 0, -20 << 16, 0, 180 << 16, 0, 1 << 16, 3 << 16));
    // bearings in the second, third and fourth quadrants
    send_query(mk(0, 0, -7 << 16, 4 << 16, 270 << 16, 1 << 16, 3 << 16, 50 << 16));
    send_query(mk(0, 0, -7 << 16, -4 << 16, 30 << 16, 1 << 16, 3 << 16, 50 << 16));
    send_query(mk(0, 0, 7 << 16, -4 << 16, 200 << 16, 1 << 16, 3 << 16, 50 << 16));
    // field extremes and saturation of the point
    send_query(mk(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                  23592959, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    send_query(mk(32'h80000000, 0, 32'h7fff0000, 0, 0,
                  32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    send_query(mk(0, 32'h7fff0000, 0, 32'h7fff0000, 90 << 16,
                  32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    send_query(mk(0, 0, 0, 32'h80000000, 270 << 16, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    send_query(mk(32'h7fffffff, 32'h80000000, 0, 0, 0, 0, 0, 32'h7fffffff));
    send_query(mk(1, -1, -1, 1, 1, 1, 1, 1));
  endtask

  task automatic test_heading_wrap();
    // headings of 360 degrees and above fold back; 256, 180 and 90 degrees are sent too
    send_query(mk(0, 0, 3 << 16, 3 << 16, 23592960, 2 << 16, 4 << 16, 20 << 16));
    send_query(mk(0, 0, 3 << 16, 3 << 16, 33554431, 2 << 16, 4 << 16, 20 << 16));
    send_query(mk(0, 0, 3 << 16, 3 << 16, 16777216, 2 << 16, 4 << 16, 20 << 16));
    send_query(mk(0, 0, 3 << 16, 3 << 16, 11796480, 2 << 16, 4 << 16, 20 << 16));
    send_query(mk(0, 0, 3 << 16, 3 << 16, 5898240, 2 << 16, 4 << 16, 20 << 16));
  endtask

  task automatic wait_drained();
    while (pending_intercepts.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_random_sweep(input int count);
    for (int i = 0; i < count; i++)
      send_query(make_query($urandom_range(0, 9) < 8));
  endtask

  task automatic test_back_to_back(input int count);
    no_idle = 1'b1;
    for (int i = 0; i < count; i++) send_query(make_query(1'b1));
    no_idle = 1'b0;
  endtask

  task automatic test_drain_pause();
    release_input();
    wait_drained();
    send_query(make_query(1'b1));
  endtask

  initial begin : stimulus
    in_valid_i = 1'b0;
    out_ready_i = 1'b0;
    pursuer_x_i = '0; pursuer_y_i = '0; target_x_i = '0; target_y_i = '0;
    heading_deg_i = '0; target_speed_i = '0; pursuer_speed_i = '0; time_limit_i = '0;
    mismatches = 0; words_sent = 0; words_checked = 0; found_count = 0; no_idle = 1'b0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_edges();
    test_heading_wrap();
    test_random_sweep(200);
    test_drain_pause();
    test_back_to_back(60);
    test_random_sweep(220);
    release_input();
    wait_drained();
    repeat (300) @(posedge clk_i);
    $display("sent %0d queries, checked %0d words, %0d with an intercept",
             words_sent, words_checked, found_count);
    $display("covered extremes, heading wrap, saturation and idle/stall patterns");
    if (mismatches == 0) begin
      $display("pursuit_intercept_solver test passed");
    end else begin
      $display("pursuit_intercept_solver test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("pursuit_intercept_solver test failed");
    $finish;
  end

endmodule
